>>> rtl/jp2_box_extract_defines.svh
// Assertion macros used by the box extractor top level.
`ifndef JP2_BOX_EXTRACT_DEFINES_SVH
`define JP2_BOX_EXTRACT_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define JBX_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define JBX_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/jbx_pkg.sv
// Types and constants of the JP2 box extractor.
`default_nettype none
package jbx_pkg;

    localparam int OFF_W = 48;

    typedef logic [OFF_W-1:0] t_off;

    typedef enum logic [2:0] {
        PH_HEADER,
        PH_SKIP,
        PH_EMIT,
        PH_FOUND,
        PH_NOMORE,
        PH_BAD
    } t_phase;

    typedef enum logic {
        OP_BEAT,
        OP_HDR
    } t_op;

    localparam logic [1:0] KIND_BYTE      = 2'd0;
    localparam logic [1:0] KIND_NOT_FOUND = 2'd1;
    localparam logic [1:0] KIND_BAD_LEN   = 2'd2;
    localparam logic [1:0] KIND_EMPTY     = 2'd3;

    localparam logic REG_TARGET_TYPE    = 1'b0;
    localparam logic REG_INCLUDE_HEADER = 1'b1;

    localparam logic [4:0] HDR_SHORT = 5'd8;
    localparam logic [4:0] HDR_LONG  = 5'd16;
    localparam logic [3:0] HDR_LAST_SHORT = 4'd7;
    localparam logic [3:0] HDR_LAST_LONG  = 4'd15;

    localparam logic [31:0] LBOX_TO_END    = 32'd0;
    localparam logic [31:0] LBOX_EXTENDED  = 32'd1;
    localparam logic [31:0] LBOX_MIN_PLAIN = 32'd8;

    typedef struct packed {
        t_op               op;
        logic [1:0]        kind;
        logic [7:0]        bval;
        logic              last;
        logic              hdr_long;
        t_off              offset;
        logic [15:0][7:0]  hdr;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic nonempty;
    } t_q_stat;

endpackage
`default_nettype wire

>>> rtl/jbx_front.sv
// Front end: box header walker that turns file bytes into output commands.
`default_nettype none
module jbx_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic [7:0]      i_file_byte,
    input  wire logic            i_end_of_file,
    input  wire logic            i_cfg_valid,
    input  wire logic            i_cfg_index,
    input  wire logic [31:0]     i_cfg_data,
    input  wire jbx_pkg::t_q_stat i_q_stat,
    output logic                 o_push,
    output jbx_pkg::t_cmd        o_cmd
);

    logic [31:0]            r_target_type;
    logic                   r_include_header;

    jbx_pkg::t_phase        r_phase, n_phase, w_walk_phase;
    logic [4:0]             r_idx, n_idx;
    jbx_pkg::t_off          r_pos, n_pos;
    jbx_pkg::t_off          r_start, n_start;
    logic [63:0]            r_bl, n_bl;
    logic                   r_to_end, n_to_end;
    logic [15:0][7:0]       r_hdr;

    logic                   w_accept;
    logic [15:0][7:0]       w_hv;
    logic [4:0]             w_idx_inc;
    logic                   w_hdr_done;
    logic                   w_wait_ext;
    logic [31:0]            w_lbox;
    logic [31:0]            w_tbox;
    logic [63:0]            w_len;
    logic [63:0]            w_hlen;
    logic [63:0]            w_rem;
    logic [63:0]            w_bl_dec;
    logic                   w_bad;
    logic                   w_match;
    logic                   w_empty;
    logic                   w_emit_last;
    jbx_pkg::t_off          w_start;

    assign o_in_ready = !i_q_stat.full;
    assign w_accept   = i_in_valid && !i_q_stat.full;

    // header decode, with the incoming byte merged in
    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_hv[k] = (r_idx[3:0] == 4'(k)) ? i_file_byte : r_hdr[k];
        end
    end

    assign w_idx_inc  = r_idx + 5'd1;
    assign w_hdr_done = (w_idx_inc == jbx_pkg::HDR_SHORT) || (w_idx_inc == jbx_pkg::HDR_LONG);
    assign w_lbox     = {w_hv[0], w_hv[1], w_hv[2], w_hv[3]};
    assign w_tbox     = {w_hv[4], w_hv[5], w_hv[6], w_hv[7]};
    assign w_wait_ext = (w_lbox == jbx_pkg::LBOX_EXTENDED) && (w_idx_inc == jbx_pkg::HDR_SHORT);
    assign w_len      = (w_lbox == jbx_pkg::LBOX_EXTENDED)
                        ? {w_hv[8], w_hv[9], w_hv[10], w_hv[11],
                           w_hv[12], w_hv[13], w_hv[14], w_hv[15]}
                        : {32'd0, w_lbox};
    assign w_hlen     = {59'd0, w_idx_inc};
    assign w_rem      = w_len - w_hlen;
    assign w_bl_dec   = r_bl - 64'd1;
    assign w_bad      = ((w_lbox > jbx_pkg::LBOX_EXTENDED) && (w_lbox < jbx_pkg::LBOX_MIN_PLAIN))
                        || ((w_lbox == jbx_pkg::LBOX_EXTENDED)
                            && (w_len < 64'(jbx_pkg::HDR_LONG)));
    assign w_match    = (w_tbox == r_target_type);
    assign w_empty    = (w_lbox == jbx_pkg::LBOX_TO_END) ? i_end_of_file : (w_len == w_hlen);
    assign w_emit_last = r_to_end ? i_end_of_file : ((w_bl_dec == 64'd0) || i_end_of_file);
    assign w_start    = ((r_phase == jbx_pkg::PH_HEADER) && (r_idx == 5'd0)) ? r_pos : r_start;

    // next state
    always_comb begin
        w_walk_phase = r_phase;
        n_idx        = r_idx;
        n_pos        = r_pos;
        n_start      = r_start;
        n_bl         = r_bl;
        n_to_end     = r_to_end;
        if (w_accept) begin
            n_pos = r_pos + jbx_pkg::t_off'(1);
            case (r_phase)
                jbx_pkg::PH_HEADER: begin
                    n_start = w_start;
                    if (!w_hdr_done || w_wait_ext) begin
                        n_idx = w_idx_inc;
                    end else begin
                        n_idx = 5'd0;
                        if (w_bad) begin
                            w_walk_phase = jbx_pkg::PH_BAD;
                        end else if (w_match) begin
                            if (w_empty) begin
                                w_walk_phase = jbx_pkg::PH_FOUND;
                            end else begin
                                w_walk_phase = jbx_pkg::PH_EMIT;
                                n_to_end = (w_lbox == jbx_pkg::LBOX_TO_END);
                                n_bl = (w_lbox == jbx_pkg::LBOX_TO_END) ? 64'd0 : w_rem;
                            end
                        end else if (w_lbox == jbx_pkg::LBOX_TO_END) begin
                            w_walk_phase = jbx_pkg::PH_NOMORE;
                        end else begin
                            n_bl = w_rem;
                            w_walk_phase = (w_rem != 64'd0) ? jbx_pkg::PH_SKIP
                                                            : jbx_pkg::PH_HEADER;
                        end
                    end
                end
                jbx_pkg::PH_SKIP: begin
                    n_bl = w_bl_dec;
                    if (w_bl_dec == 64'd0) begin
                        w_walk_phase = jbx_pkg::PH_HEADER;
                    end
                end
                jbx_pkg::PH_EMIT: begin
                    if (!r_to_end) begin
                        n_bl = w_bl_dec;
                    end
                    if (w_emit_last) begin
                        w_walk_phase = jbx_pkg::PH_FOUND;
                    end
                end
                default: begin
                end
            endcase
        end
        n_phase = w_walk_phase;
        if (w_accept && i_end_of_file) begin
            n_phase  = jbx_pkg::PH_HEADER;
            n_idx    = 5'd0;
            n_pos    = '0;
            n_start  = '0;
            n_bl     = 64'd0;
            n_to_end = 1'b0;
        end
    end

    // command out
    always_comb begin
        o_push       = 1'b0;
        o_cmd.op       = jbx_pkg::OP_BEAT;
        o_cmd.kind     = jbx_pkg::KIND_BYTE;
        o_cmd.bval     = 8'd0;
        o_cmd.last     = 1'b0;
        o_cmd.hdr_long = (w_idx_inc == jbx_pkg::HDR_LONG);
        o_cmd.offset   = w_start;
        o_cmd.hdr      = w_hv;
        if (w_accept) begin
            case (r_phase)
                jbx_pkg::PH_HEADER: begin
                    if (w_hdr_done && !w_wait_ext) begin
                        if (w_bad) begin
                            o_push     = 1'b1;
                            o_cmd.kind = jbx_pkg::KIND_BAD_LEN;
                        end else if (w_match) begin
                            if (r_include_header) begin
                                o_push     = 1'b1;
                                o_cmd.op   = jbx_pkg::OP_HDR;
                                o_cmd.last = w_empty;
                            end else if (w_empty) begin
                                o_push     = 1'b1;
                                o_cmd.kind = jbx_pkg::KIND_EMPTY;
                                o_cmd.last = 1'b1;
                            end
                        end
                    end
                end
                jbx_pkg::PH_EMIT: begin
                    o_push     = 1'b1;
                    o_cmd.bval = i_file_byte;
                    o_cmd.last = w_emit_last;
                end
                default: begin
                end
            endcase
            if (i_end_of_file && (w_walk_phase inside
                    {jbx_pkg::PH_HEADER, jbx_pkg::PH_SKIP, jbx_pkg::PH_NOMORE})) begin
                o_push       = 1'b1;
                o_cmd.op     = jbx_pkg::OP_BEAT;
                o_cmd.kind   = jbx_pkg::KIND_NOT_FOUND;
                o_cmd.bval   = 8'd0;
                o_cmd.last   = 1'b0;
                o_cmd.offset = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= jbx_pkg::PH_HEADER;
            r_idx    <= 5'd0;
            r_pos    <= '0;
            r_start  <= '0;
            r_bl     <= 64'd0;
            r_to_end <= 1'b0;
        end else begin
            r_phase  <= n_phase;
            r_idx    <= n_idx;
            r_pos    <= n_pos;
            r_start  <= n_start;
            r_bl     <= n_bl;
            r_to_end <= n_to_end;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept && (r_phase == jbx_pkg::PH_HEADER)) begin
            r_hdr[r_idx[3:0]] <= i_file_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target_type    <= 32'd0;
            r_include_header <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                jbx_pkg::REG_TARGET_TYPE:    r_target_type    <= i_cfg_data;
                jbx_pkg::REG_INCLUDE_HEADER: r_include_header <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/jbx_queue.sv
// Two-entry command queue between the header walker and the beat generator.
`default_nettype none
module jbx_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire jbx_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output jbx_pkg::t_cmd      o_head,
    output jbx_pkg::t_q_stat   o_stat
);

    jbx_pkg::t_cmd r_ent [2];
    logic          r_wr;
    logic          r_rd;
    logic [1:0]    r_count;

    assign o_head          = r_ent[r_rd];
    assign o_stat.full     = (r_count == 2'd2);
    assign o_stat.nonempty = (r_count != 2'd0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_ent[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= 1'b0;
            r_rd    <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (i_pop) begin
                r_rd <= ~r_rd;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule
`default_nettype wire

>>> rtl/jbx_back.sv
// Back end: expands queued commands into output beats through an output register.
`default_nettype none
module jbx_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire jbx_pkg::t_cmd i_head,
    input  wire logic          i_nonempty,
    output logic               o_pop,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output logic [1:0]         o_kind,
    output logic [7:0]         o_out_byte,
    output logic               o_last_of_box,
    output logic [jbx_pkg::OFF_W-1:0] o_box_offset
);

    logic [3:0]  r_idx;
    logic        r_valid;
    logic [1:0]  r_kind;
    logic [7:0]  r_byte;
    logic        r_last;
    jbx_pkg::t_off r_offset;

    logic        w_load;
    logic        w_fire;
    logic        w_done;
    logic [3:0]  w_last_idx;
    logic [1:0]  w_kind;
    logic [7:0]  w_byte;
    logic        w_last;

    assign w_load     = !r_valid || i_out_ready;
    assign w_fire     = w_load && i_nonempty;
    assign w_last_idx = i_head.hdr_long ? jbx_pkg::HDR_LAST_LONG : jbx_pkg::HDR_LAST_SHORT;

    always_comb begin
        if (i_head.op == jbx_pkg::OP_HDR) begin
            w_kind = jbx_pkg::KIND_BYTE;
            w_byte = i_head.hdr[r_idx];
            w_done = (r_idx == w_last_idx);
            w_last = i_head.last && w_done;
        end else begin
            w_kind = i_head.kind;
            w_byte = i_head.bval;
            w_done = 1'b1;
            w_last = i_head.last;
        end
    end

    assign o_pop = w_fire && w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 4'd0;
            r_valid <= 1'b0;
        end else begin
            if (w_load) begin
                r_valid <= i_nonempty;
            end
            if (w_fire) begin
                r_idx <= w_done ? 4'd0 : r_idx + 4'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_kind   <= w_kind;
            r_byte   <= w_byte;
            r_last   <= w_last;
            r_offset <= i_head.offset;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_kind        = r_kind;
    assign o_out_byte    = r_byte;
    assign o_last_of_box = r_last;
    assign o_box_offset  = r_offset;

endmodule
`default_nettype wire

>>> rtl/jp2_box_extract.sv
// Top level of the JP2 box extractor: walker, command queue and beat generator.
//
// channel   direction  handshake                  payload
// in        sink       i_in_valid / o_in_ready    i_file_byte, i_end_of_file
// out       source     o_out_valid / i_out_ready  o_kind, o_out_byte, o_last_of_box,
//                                                 o_box_offset
// cfg       sink       i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// One input beat per cycle while the queue is not full; each output beat is queued as a
// command and then leaves through the output register.
// A header burst of 8 or 16 output beats comes from one queue entry at one beat per
// cycle while the output is not stalled; input stalls once the two-entry queue fills behind it.
// Sync active-low reset clears walker state and both config registers; no clearing pass.
// Output stall backs up through the queue to o_in_ready; cfg beats are always taken.
`default_nettype none
`include "jp2_box_extract_defines.svh"
module jp2_box_extract (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_file_byte,
    input  wire logic        i_end_of_file,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [1:0]       o_kind,
    output logic [7:0]       o_out_byte,
    output logic             o_last_of_box,
    output logic [jbx_pkg::OFF_W-1:0] o_box_offset,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    logic             w_push;
    logic             w_pop;
    jbx_pkg::t_cmd    w_cmd;
    jbx_pkg::t_cmd    w_head;
    jbx_pkg::t_q_stat w_q_stat;

    assign o_cfg_ready = 1'b1;

    jbx_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_file_byte   (i_file_byte),
        .i_end_of_file (i_end_of_file),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_q_stat      (w_q_stat),
        .o_push        (w_push),
        .o_cmd         (w_cmd)
    );

    jbx_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    jbx_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (w_head),
        .i_nonempty    (w_q_stat.nonempty),
        .o_pop         (w_pop),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_last_of_box (o_last_of_box),
        .o_box_offset  (o_box_offset)
    );

    `JBX_ASSERT_IMP(a_status_byte_zero, o_out_valid && (o_kind != jbx_pkg::KIND_BYTE), o_out_byte == 8'd0, "status beat carries a nonzero byte")
    `JBX_ASSERT_IMP(a_not_found_clean, o_out_valid && (o_kind == jbx_pkg::KIND_NOT_FOUND), (o_box_offset == 48'd0) && !o_last_of_box, "not-found beat has offset or last set")
    `JBX_ASSERT_IMP(a_empty_is_last, o_out_valid && (o_kind == jbx_pkg::KIND_EMPTY), o_last_of_box, "empty-box beat not marked last")
    `JBX_ASSERT_NXT(a_queue_keeps, w_q_stat.nonempty && !w_pop, w_q_stat.nonempty, "queued command lost without a pop")

endmodule
`default_nettype wire

>>> dv/tb.sv
// Self-checking testbench for jp2_box_extract: random JP2 box streams, checked beat by beat.
`timescale 1ns / 1ps

import jbx_pkg::*;

typedef struct packed {
    logic [1:0] kind;
    logic [7:0] bval;
    logic       last;
    t_off       off;
} box_beat_t;

class box_scoreboard;
    box_beat_t   expected_q[$];
    int          errors;
    int          n_bytes;
    int          n_empty;
    int          n_not_found;
    int          n_bad_len;
    logic [31:0] target;
    logic        inc_hdr;
    t_off        pos;
    t_off        box_start;
    t_phase      walk_state;
    logic [4:0]  hdr_idx;
    logic [7:0]  hdr[16];
    logic [63:0] left;
    logic        to_end;

    function new();
        target = '0;
        inc_hdr = 1'b0;
        foreach (hdr[i]) hdr[i] = '0;
        restart();
    endfunction

    function void restart();
        pos = '0;
        box_start = '0;
        walk_state = PH_HEADER;
        hdr_idx = '0;
        left = '0;
        to_end = 1'b0;
    endfunction

    function void set_reg(logic idx, logic [31:0] d);
        case (idx)
            REG_TARGET_TYPE: target = d;
            REG_INCLUDE_HEADER: inc_hdr = d[0];
            default: ;
        endcase
    endfunction

    function void push(logic [1:0] kind, logic [7:0] b, logic last, t_off off);
        case (kind)
            KIND_BYTE: n_bytes++;
            KIND_EMPTY: n_empty++;
            KIND_NOT_FOUND: n_not_found++;
            default: n_bad_len++;
        endcase
        expected_q.push_back('{kind: kind, bval: b, last: last, off: off});
    endfunction

    function void note_byte(logic [7:0] b, logic eof);
        logic [31:0] lbox;
        logic [31:0] tbox;
        logic [63:0] len;
        int          hdr_len;
        logic        empty;
        logic        last;
        case (walk_state)
            PH_HEADER: begin
                if (hdr_idx == 0) box_start = pos;
                hdr[hdr_idx[3:0]] = b;
                hdr_idx++;
                if (hdr_idx == HDR_SHORT || hdr_idx == HDR_LONG) begin
                    lbox = {hdr[0], hdr[1], hdr[2], hdr[3]};
                    tbox = {hdr[4], hdr[5], hdr[6], hdr[7]};
                    hdr_len = hdr_idx;
                    if (!(lbox == LBOX_EXTENDED && hdr_idx == HDR_SHORT)) begin
                        len = (lbox == LBOX_EXTENDED) ?
                            {hdr[8], hdr[9], hdr[10], hdr[11], hdr[12], hdr[13], hdr[14],
                             hdr[15]} : 64'(lbox);
                        hdr_idx = '0;
                        if ((lbox > LBOX_EXTENDED && lbox < LBOX_MIN_PLAIN) ||
                            (lbox == LBOX_EXTENDED && len < 64'(HDR_LONG))) begin
                            push(KIND_BAD_LEN, '0, 1'b0, box_start);
                            walk_state = PH_BAD;
                        end else if (tbox == target) begin
                            empty = (lbox == LBOX_TO_END) ? eof : (len == 64'(hdr_len));
                            if (inc_hdr) begin
                                for (int i = 0; i < hdr_len; i++)
                                    push(KIND_BYTE, hdr[i], empty && (i == hdr_len - 1),
                                         box_start);
                            end else if (empty) begin
                                push(KIND_EMPTY, '0, 1'b1, box_start);
                            end
                            if (empty) begin
                                walk_state = PH_FOUND;
                            end else begin
                                walk_state = PH_EMIT;
                                to_end = (lbox == LBOX_TO_END);
                                left = to_end ? '0 : len - 64'(hdr_len);
                            end
                        end else if (lbox == LBOX_TO_END) begin
                            walk_state = PH_NOMORE;
                        end else begin
                            left = len - 64'(hdr_len);
                            walk_state = (left != 0) ? PH_SKIP : PH_HEADER;
                        end
                    end
                end
            end
            PH_SKIP: begin
                left--;
                if (left == 0) walk_state = PH_HEADER;
            end
            PH_EMIT: begin
                if (to_end) begin
                    last = eof;
                end else begin
                    left--;
                    last = (left == 0) || eof;
                end
                push(KIND_BYTE, b, last, box_start);
                if (last) walk_state = PH_FOUND;
            end
            default: ;
        endcase
        pos++;
        if (eof) begin
            if (walk_state == PH_HEADER || walk_state == PH_SKIP || walk_state == PH_NOMORE)
                push(KIND_NOT_FOUND, '0, 1'b0, '0);
            restart();
        end
    endfunction

    function void check_beat(box_beat_t got);
        box_beat_t want;
        if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat kind=%0d byte=%02h last=%0b offset=%0d",
                     $time, got.kind, got.bval, got.last, got.off);
        end else begin
            want = expected_q.pop_front();
            if (got !== want) begin
                errors++;
                $display("%0t: mismatch, expected kind=%0d byte=%02h last=%0b offset=%0d",
                         $time, want.kind, want.bval, want.last, want.off);
                $display("%0t:           actual   kind=%0d byte=%02h last=%0b offset=%0d",
                         $time, got.kind, got.bval, got.last, got.off);
            end
        end
    endfunction

    function int pending();
        return expected_q.size();
    endfunction
endclass

module tb;
    localparam int CFG_PHASES   = 6;
    localparam int PHASE_ITEMS  = 8;
    localparam int IDLE_CYCLES  = 20;
    localparam int HOLD_CYCLES  = 60;
    localparam int DRAIN_CYCLES = 40;
    localparam logic [31:0] TARGETS [CFG_PHASES] =
        '{32'hFFFF_FFFF, 32'h0000_0000, 32'h6A70_3268, 32'h0000_0000, 32'h7575_6964,
          32'h0000_0000};
    localparam bit HDR_MODES [CFG_PHASES] = '{1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

    typedef enum {BOX_PLAIN, BOX_EXT, BOX_TO_END, BOX_RESERVED, BOX_SHORT_EXT} box_form_e;

    logic        i_clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  file_byte = '0;
    logic        end_of_file = 1'b0;
    logic        out_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_index = REG_TARGET_TYPE;
    logic [31:0] cfg_data = '0;
    logic        o_in_ready;
    logic        o_out_valid;
    logic [1:0]  o_kind;
    logic [7:0]  o_out_byte;
    logic        o_last_of_box;
    logic [47:0] o_box_offset;
    logic        o_cfg_ready;

    box_scoreboard sb = new();
    logic [7:0]    file_bytes[$];
    int            cfg_phase = -1;
    int            hold_phase = -1;
    bit            rx_hold = 1'b0;
    bit            rx_burst = 1'b0;
    bit            tx_burst = 1'b0;
    bit            tx_in_file = 1'b0;
    int            files_sent = 0;
    int            bytes_sent = 0;
    int            beats_seen = 0;

    jp2_box_extract i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (rst_n),
        .i_in_valid    (in_valid),
        .o_in_ready    (o_in_ready),
        .i_file_byte   (file_byte),
        .i_end_of_file (end_of_file),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (out_ready),
        .o_kind        (o_kind),
        .o_out_byte    (o_out_byte),
        .o_last_of_box (o_last_of_box),
        .o_box_offset  (o_box_offset),
        .i_cfg_valid   (cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #5ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    function automatic void add_be(logic [63:0] v, int n);
        for (int i = n - 1; i >= 0; i--) file_bytes.push_back(v[8*i +: 8]);
    endfunction

    function automatic logic [31:0] pick_type();
        case ($urandom_range(0, 3))
            0, 1: return sb.target;
            2: return $urandom;
            default: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
        endcase
    endfunction

    function automatic void add_box(logic [31:0] typ, int body, box_form_e form);
        case (form)
            BOX_PLAIN: add_be(64'(8 + body), 4);
            BOX_TO_END: add_be(64'(LBOX_TO_END), 4);
            BOX_RESERVED: add_be(64'($urandom_range(2, LBOX_MIN_PLAIN - 1)), 4);
            default: add_be(64'(LBOX_EXTENDED), 4);
        endcase
        add_be(64'(typ), 4);
        if (form == BOX_EXT) add_be(64'(16 + body), 8);
        else if (form == BOX_SHORT_EXT) add_be(64'($urandom_range(0, 15)), 8);
        repeat (body) file_bytes.push_back(8'($urandom_range(0, 255)));
    endfunction

    // mostly well-formed box chains; some malformed, truncated or pure noise
    function automatic void make_file();
        int        sel;
        int        nbox;
        box_form_e form;
        file_bytes.delete();
        sel = $urandom_range(0, 9);
        if (sel == 7) begin
            if ($urandom_range(0, 1)) add_box(pick_type(), $urandom_range(0, 3), BOX_PLAIN);
            add_box(pick_type(), 0, $urandom_range(0, 1) ? BOX_RESERVED : BOX_SHORT_EXT);
            repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));
        end else if (sel == 9) begin
            repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
        end else begin
            nbox = $urandom_range(1, 2);
            for (int k = 0; k < nbox; k++) begin
                if (k == nbox - 1 && $urandom_range(0, 2) == 0) form = BOX_TO_END;
                else form = ($urandom_range(0, 3) == 0) ? BOX_EXT : BOX_PLAIN;
                add_box(pick_type(), $urandom_range(0, 5), form);
            end
            if (sel == 8) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
        end
    endfunction

    task automatic send_byte(logic [7:0] b, logic eof);
        int gap;
        @(negedge i_clk);
        gap = (rx_hold || tx_burst) ? 0 : $urandom_range(0, 9);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_valid <= 1'b1;
        file_byte <= b;
        end_of_file <= eof;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        sb.note_byte(b, eof);
        bytes_sent++;
    endtask

    task automatic send_file();
        tx_burst = ($urandom_range(0, 3) == 0);
        foreach (file_bytes[i]) send_byte(file_bytes[i], i == file_bytes.size() - 1);
        files_sent++;
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (IDLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [31:0] d);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        sb.set_reg(idx, d);
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    initial begin : beat_sink
        int gap;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge i_clk);
            if (tx_in_file && hold_phase != cfg_phase &&
                (hold_phase < 0 || $urandom_range(0, 7) == 0)) begin
                // long stall so the queue fills and backs up into the input
                hold_phase = cfg_phase;
                rx_hold = 1'b1;
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                rx_hold = 1'b0;
                out_ready <= 1'b1;
            end else begin
                if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
                gap = rx_burst ? 0 : $urandom_range(0, 9);
                if (gap > 0) begin
                    out_ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
                out_ready <= 1'b1;
            end
            @(posedge i_clk);
            while (!o_out_valid) @(posedge i_clk);
            sb.check_beat('{kind: o_kind, bval: o_out_byte, last: o_last_of_box,
                            off: o_box_offset});
            beats_seen++;
        end
    end

    initial begin : stimulus
        int          phase_items;
        logic [31:0] tgt;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        rst_n <= 1'b1;

        // empty box of type 0, reserved length, lone byte, one-byte payload
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h08, 8'h00, 8'h00, 8'h00, 8'h00};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h03, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_file();
        file_bytes = '{8'hFF};
        send_file();
        file_bytes = '{8'h00, 8'h00, 8'h00, 8'h09, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_file();

        for (int p = 0; p < CFG_PHASES; p++) begin
            wait_idle();
            cfg_phase = p;
            tgt = (p == 3) ? $urandom : TARGETS[p];
            write_reg(REG_TARGET_TYPE, tgt);
            write_reg(REG_INCLUDE_HEADER, 32'(HDR_MODES[p]));
            phase_items = 0;
            tx_in_file = 1'b1;
            while (phase_items < PHASE_ITEMS) begin
                make_file();
                phase_items += file_bytes.size();
                send_file();
            end
            tx_in_file = 1'b0;
        end

        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("Ran %0d file bytes in %0d files over %0d register settings.",
                 bytes_sent, files_sent, CFG_PHASES + 1);
        $display("Checked %0d beats: %0d box bytes, %0d empty, %0d not found, %0d bad length.",
                 beats_seen, sb.n_bytes, sb.n_empty, sb.n_not_found, sb.n_bad_len);
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end
endmodule

>>> sim.f
+incdir+rtl
rtl/jbx_pkg.sv
rtl/jbx_front.sv
rtl/jbx_queue.sv
rtl/jbx_back.sv
rtl/jp2_box_extract.sv
dv/tb.sv
